// ===== hw/rtl/u8dct_pkg.sv =====
// Shared types and constants for the UTF-8 decode/count/truncate block.
`timescale 1ns / 1ps
package u8dct_pkg;

	localparam logic [31:0] MAX_UNITS_DEF = 32'd65535;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned CP_W = 21;

	// register map (word index in paddr[2])
	localparam logic REG_COLUMN_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] COLUMN_LIMIT_RST = 16'hFFFF;

	// lead byte patterns
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL = 8'hC0;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL = 8'hE0;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL = 8'hF0;
	localparam logic [7:0] LEAD4_BITS = 8'h07;
	localparam logic [7:0] CONT_MARK = 8'h80;
	localparam logic [7:0] CONT_BITS = 8'h3F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0]    code_point;
		logic               invalid;
		logic [2:0]         unit_bytes;
		logic [LIMIT_W-1:0] units_so_far;
		logic               within_limit;
		logic               run_last;
		logic               string_last;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // take the input byte into the queue
		logic emit;    // write the unit at head into the output register
		logic finish;  // compact leftovers into the held area, close the byte
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic unit_ok;    // a unit can be produced at head
		logic unit_last;  // no further unit follows it for this byte
		logic out_free;   // output register can take a unit this cycle
	} status_t;

endpackage

// ===== hw/rtl/u8dct_dp.sv =====
// Datapath: byte queue, unit decoder, unit counter and output register.
`timescale 1ns / 1ps
module u8dct_dp
	import u8dct_pkg::*;
#(
	parameter logic [31:0] MAX_UNITS = MAX_UNITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  in_item_t           in_data,
	input  logic [LIMIT_W-1:0] column_limit,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	localparam logic [LIMIT_W-1:0] CAP =
		(MAX_UNITS > 32'd65535) ? 16'hFFFF : MAX_UNITS[LIMIT_W-1:0];

	typedef struct packed {
		logic            emit;
		logic            bad;
		logic [CP_W-1:0] cp;
		logic [2:0]      len;
	} dec_t;

	// Look at the queue from position hd and say which unit, if any, starts there.
	function automatic dec_t decode(input logic [3:0][7:0] q, input logic [2:0] qn,
			input logic [2:0] hd, input logic eos);
		dec_t       d;
		logic [2:0] avail;
		logic [7:0] c;
		logic [7:0] cc;
		logic [2:0] need;
		logic [2:0] idx;
		logic [CP_W-1:0] acc;
		logic       broken;
		logic       lead;
		avail = qn - hd;
		c = q[hd[1:0]];
		d = '0;
		d.cp = {13'd0, c};
		d.len = 3'd1;
		need = 3'd1;
		acc = '0;
		lead = 1'b1;
		broken = 1'b0;
		cc = '0;
		if ((c & LEAD2_MASK) == LEAD2_VAL) begin
			need = 3'd2;
			acc = {13'd0, c & LEAD2_BITS};
		end else if ((c & LEAD3_MASK) == LEAD3_VAL) begin
			need = 3'd3;
			acc = {13'd0, c & LEAD3_BITS};
		end else if ((c & LEAD4_MASK) == LEAD4_VAL) begin
			need = 3'd4;
			acc = {13'd0, c & LEAD4_BITS};
		end else begin
			lead = 1'b0;
		end
		for (int i = 1; i < 4; i++) begin
			idx = hd + 3'(i);
			if (3'(i) < need && 3'(i) < avail && !broken) begin
				cc = q[idx[1:0]];
				if ((cc & ~CONT_BITS) != CONT_MARK) begin
					broken = 1'b1;
				end else begin
					acc = {acc[CP_W-7:0], cc[5:0]};
				end
			end
		end
		if (avail == 3'd0) begin
			d.emit = 1'b0;
		end else if (!c[7]) begin
			d.emit = 1'b1;
		end else if (!lead) begin
			d.emit = 1'b1;
			d.bad = 1'b1;
		end else if (broken || (avail < need && eos)) begin
			d.emit = 1'b1;
			d.bad = 1'b1;
		end else if (avail < need) begin
			d.emit = 1'b0;
		end else begin
			d.emit = 1'b1;
			d.cp = acc;
			d.len = need;
		end
		return d;
	endfunction

	logic [3:0][7:0]    q_q;
	logic [2:0]         qn_q;
	logic [2:0]         hd_q;
	logic               eos_q;
	logic [1:0]         held_q;
	logic [LIMIT_W-1:0] cnt_q;
	out_item_t          out_q;
	logic               out_valid_q;

	dec_t               cur;
	dec_t               nxt;
	logic [2:0]         hd_adv;
	logic [2:0]         rem;
	logic [LIMIT_W-1:0] cnt_inc;

	always_comb begin
		cur = decode(q_q, qn_q, hd_q, eos_q);
		hd_adv = hd_q + (cur.emit ? cur.len : 3'd0);
		nxt = decode(q_q, qn_q, hd_adv, eos_q);
		rem = qn_q - hd_adv;
		cnt_inc = (cnt_q < CAP) ? cnt_q + 16'd1 : cnt_q;
	end

	assign status.unit_ok = cur.emit;
	assign status.unit_last = !nxt.emit;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// queue payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q[held_q] <= in_data.in_byte;
		end else if (cmd.finish) begin
			for (int j = 0; j < 3; j++) begin
				q_q[2'(j)] <= q_q[2'(hd_adv + 3'(j))];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.code_point <= cur.cp;
			out_q.invalid <= cur.bad;
			out_q.unit_bytes <= cur.len;
			out_q.units_so_far <= cnt_inc;
			out_q.within_limit <= (column_limit != '0) && (cnt_inc <= column_limit);
			out_q.run_last <= !nxt.emit;
			out_q.string_last <= !nxt.emit && eos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= '0;
			hd_q <= '0;
			eos_q <= 1'b0;
			held_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				qn_q <= {1'b0, held_q} + 3'd1;
				hd_q <= '0;
				eos_q <= in_data.end_of_string;
			end
			if (cmd.emit) begin
				hd_q <= hd_adv;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// end of string clears the count, even on the edge of its last unit
			if (cmd.finish && eos_q) begin
				cnt_q <= '0;
			end else if (cmd.emit) begin
				cnt_q <= cnt_inc;
			end
			if (cmd.finish) begin
				held_q <= eos_q ? 2'd0 : rem[1:0];
			end
		end
	end

endmodule

// ===== hw/rtl/u8dct_ctrl.sv =====
// Controller: takes one byte, then steps out its units one per cycle while the output is free.
`timescale 1ns / 1ps
module u8dct_ctrl
	import u8dct_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (!status.unit_ok || (status.out_free && status.unit_last)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.emit = status.unit_ok && status.out_free;
				cmd.finish = !status.unit_ok || (status.out_free && status.unit_last);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/utf8_decode_count_truncate_top.sv =====
// Top level of the streaming UTF-8 decoder with unit count and column limit.
// Each accepted byte is first loaded into the queue, and then the units it
// completes are stepped out, one per cycle while the output is not stalled,
// with a single closing step when it completes none. A byte that breaks a
// held sequence has the lead and the held bytes replayed as separate units.
// The decode step resolves one unit at the queue head per cycle.
// Bytes of an unfinished sequence are held between items (up to three). The
// end_of_string flag on a byte flushes any held bytes as invalid units and
// clears the count for the next string. column_limit sits at byte address 0
// of the register port; within_limit is set while the running count is at or
// below it and it is nonzero.
`timescale 1ns / 1ps
module utf8_decode_count_truncate_top
	import u8dct_pkg::*;
#(
	parameter logic [31:0] MAX_UNITS = MAX_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	// unit output
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [LIMIT_W-1:0] column_limit_q;
	cmd_t               cmd;
	status_t            status;
	logic               busy;

	// register write completes on the access phase; pready is tied high
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_limit_q <= COLUMN_LIMIT_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_COLUMN_LIMIT)) begin
			column_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// reads of unmapped addresses return zero
	assign prdata = (paddr[2] == REG_COLUMN_LIMIT) ? {16'd0, column_limit_q} : 32'd0;

	// input is taken only when the controller is idle
	assign in_stall = busy;

	u8dct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (busy),
		.status   (status),
		.cmd      (cmd)
	);

	u8dct_dp #(
		.MAX_UNITS (MAX_UNITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_data      (in_data),
		.column_limit (column_limit_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule

// ===== sim/utf8_decode_count_truncate_checker.sv =====
// Checker for the UTF-8 decoder: predicts units from accepted bytes and compares results.
`timescale 1ns / 1ps
module utf8_unit_checker
	import u8dct_pkg::*;
#(
	parameter logic [31:0] MAX_UNITS = MAX_UNITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          units_pending,
	output int          units_checked,
	output int          invalid_units
);

	localparam int unsigned COUNT_CAP = (MAX_UNITS > 32'd65535) ? 65535 : MAX_UNITS;
	localparam int REPORT_MAX = 30;

	logic [7:0]         held [3];
	int                 held_n;
	logic [LIMIT_W-1:0] unit_count;
	logic [LIMIT_W-1:0] column_limit;
	out_item_t          units_due [$];
	int                 fails;
	int                 checked;
	int                 invalids;

	task automatic note_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= REPORT_MAX)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
		end
	endtask

	task automatic queue_unit(input logic [CP_W-1:0] cp, input logic bad,
			input logic [2:0] len);
		out_item_t u;
		if (unit_count < COUNT_CAP)
			unit_count++;
		u.code_point   = cp;
		u.invalid      = bad;
		u.unit_bytes   = len;
		u.units_so_far = unit_count;
		u.within_limit = (column_limit != 0) && (unit_count <= column_limit);
		u.run_last     = 1'b0;
		u.string_last  = 1'b0;
		units_due.push_back(u);
	endtask

	// held bytes are replayed ahead of the new byte; one unit resolved per pass
	task automatic decode_byte(input in_item_t item);
		logic [7:0]      seq [4];
		logic [7:0]      c;
		logic [CP_W-1:0] cp;
		int              n, head, need, avail, i, first;
		logic            broken;
		out_item_t       last_unit;
		first = units_due.size();
		for (i = 0; i < held_n; i++)
			seq[i] = held[i];
		n = held_n;
		seq[n] = item.in_byte;
		n = n + 1;
		head = 0;
		while (head < n) begin
			c = seq[head];
			need = 0;
			cp = CP_W'(c);
			if (c < CONT_MARK)
				need = 1;
			else if ((c & LEAD2_MASK) == LEAD2_VAL) begin
				need = 2;
				cp = CP_W'(c & LEAD2_BITS);
			end else if ((c & LEAD3_MASK) == LEAD3_VAL) begin
				need = 3;
				cp = CP_W'(c & LEAD3_BITS);
			end else if ((c & LEAD4_MASK) == LEAD4_VAL) begin
				need = 4;
				cp = CP_W'(c & LEAD4_BITS);
			end
			if (need == 0) begin
				queue_unit(CP_W'(c), 1'b1, 3'd1);
				head++;
			end else if (need == 1) begin
				queue_unit(CP_W'(c), 1'b0, 3'd1);
				head++;
			end else begin
				avail = n - head;
				broken = 1'b0;
				for (i = 1; i < need && i < avail && !broken; i++) begin
					if ((seq[head+i] & ~CONT_BITS) != CONT_MARK)
						broken = 1'b1;
					else
						cp = {cp[CP_W-7:0], seq[head+i][5:0]};
				end
				if (broken || (avail < need && item.end_of_string)) begin
					queue_unit(CP_W'(c), 1'b1, 3'd1);
					head++;
				end else if (avail < need) begin
					break;
				end else begin
					queue_unit(cp, 1'b0, 3'(need));
					head += need;
				end
			end
		end
		held_n = 0;
		while (head < n && held_n < 3) begin
			held[held_n] = seq[head];
			held_n++;
			head++;
		end
		if (units_due.size() > first) begin
			last_unit = units_due.pop_back();
			last_unit.run_last = 1'b1;
			last_unit.string_last = item.end_of_string;
			units_due.push_back(last_unit);
		end
		if (item.end_of_string) begin
			held_n = 0;
			unit_count = '0;
		end
	endtask

	task automatic check_unit(input out_item_t got);
		out_item_t want;
		if (units_due.size() == 0) begin
			fails++;
			if (fails <= REPORT_MAX)
				$display("%0t: unit mismatch, expected none, actual 0x%0h",
					$time, got);
			return;
		end
		want = units_due.pop_front();
		checked++;
		if (want.invalid)
			invalids++;
		note_field("code_point", 32'(want.code_point), 32'(got.code_point));
		note_field("invalid", 32'(want.invalid), 32'(got.invalid));
		note_field("unit_bytes", 32'(want.unit_bytes), 32'(got.unit_bytes));
		note_field("units_so_far", 32'(want.units_so_far), 32'(got.units_so_far));
		note_field("within_limit", 32'(want.within_limit), 32'(got.within_limit));
		note_field("run_last", 32'(want.run_last), 32'(got.run_last));
		note_field("string_last", 32'(want.string_last), 32'(got.string_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_n = 0;
			unit_count = '0;
			column_limit = COLUMN_LIMIT_RST;
			units_due.delete();
			fails = 0;
			checked = 0;
			invalids = 0;
			fail_count <= 0;
			units_pending <= 0;
			units_checked <= 0;
			invalid_units <= 0;
		end else begin
			// a unit never leaves on the edge its byte enters, so order is free
			if (out_valid && !out_stall)
				check_unit(out_data);
			if (in_valid && !in_stall)
				decode_byte(in_data);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_COLUMN_LIMIT)
						column_limit = pwdata[LIMIT_W-1:0];
				end else if (paddr[2] == REG_COLUMN_LIMIT) begin
					note_field("column_limit readback", {16'h0, column_limit}, prdata);
				end
			end
			fail_count <= fails;
			units_pending <= units_due.size();
			units_checked <= checked;
			invalid_units <= invalids;
		end
	end

endmodule

// ===== sim/utf8_decode_count_truncate_top_test.sv =====
// Testbench top for the UTF-8 decoder: drives bytes and registers, gives the verdict.
`timescale 1ns / 1ps
module utf8_decode_count_truncate_top_test;
	import u8dct_pkg::*;

	localparam int CLK_HALF = 6;
	// about 410 bytes, plus stalls, drains and register traffic, stay far
	// below this
	localparam int CYCLE_LIMIT = 200_000;
	// one long ASCII string that runs past a small limit
	localparam int LONG_BYTES = 40;
	localparam logic [31:0] LONG_LIMIT = 32'd30;
	// settle time before a register write: a byte may still be in flight
	// without having produced a unit
	localparam int SETTLE = 10;
	localparam logic [2:0] LIMIT_ADDR = {REG_COLUMN_LIMIT, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = {~REG_COLUMN_LIMIT, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, units_pending, units_checked, invalid_units;
	int idle_pct = 0;       // chance per cycle that the byte side holds off
	int stall_pct = 0;      // chance per cycle that the unit side stalls
	int cycles = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	logic [LIMIT_W-1:0] mid_limit;

	utf8_decode_count_truncate_top u_top (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	utf8_unit_checker u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.fail_count, .units_pending, .units_checked, .invalid_units
	);

	always #CLK_HALF clk = ~clk;

	// receiver side: random stall, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// random lead byte opening a unit of len bytes (len 1 gives plain ASCII)
	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			1: return 8'($urandom_range(0, 127));
			2: return LEAD2_VAL | 8'($urandom_range(0, LEAD2_BITS));
			3: return LEAD3_VAL | 8'($urandom_range(0, LEAD3_BITS));
			default: return LEAD4_VAL | 8'($urandom_range(0, LEAD4_BITS));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return CONT_MARK | 8'($urandom_range(0, CONT_BITS));
	endfunction

	// one item; valid stays up through stalls, payload held until taken
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, end_of_string: eos};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// whole string, end_of_string on its final byte
	task automatic send_list(input logic [7:0] bytes [$]);
		int k;
		for (k = 0; k < bytes.size(); k++)
			send_byte(bytes[k], k == bytes.size() - 1);
		strings_sent++;
	endtask

	// sender holds off until every predicted unit has been seen; the checker's
	// count is registered, so look only after the next edge
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (units_pending != 0)
			@(posedge clk);
	endtask

	// setup phase, access phase, then the bus is released
	task automatic reg_access(input logic wr, input logic [2:0] addr,
			input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block idle; readback is checked
	task automatic set_limit(input logic [2:0] addr, input logic [31:0] value);
		drain();
		repeat (SETTLE) @(posedge clk);
		reg_access(1'b1, addr, value);
		reg_access(1'b0, LIMIT_ADDR, '0);
	endtask

	// Random string: mostly well-formed units with random payload bits,
	// some raw noise bytes, and some sequences cut short by a foreign byte.
	// A short sequence at the very end gets truncated by end_of_string.
	task automatic send_string(input int chars);
		logic [7:0] bytes [$];
		int k, j, pick, len;
		for (k = 0; k < chars; k++) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(1, 4);
			if (pick < 15) begin
				bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				bytes.push_back(lead_byte(len));
				if (pick < 80) begin
					for (j = 1; j < len; j++)
						bytes.push_back(cont_byte());
				end else if (len > 1) begin
					for (j = $urandom_range(2, len); j < len; j++)
						bytes.push_back(cont_byte());
					if (k != chars - 1 || $urandom_range(0, 1))
						bytes.push_back(lead_byte($urandom_range(1, 4)));
				end
			end
		end
		send_list(bytes);
	endtask

	task automatic run_phase(input int target);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			send_string($urandom_range(1, 10));
			if ($urandom_range(0, 19) == 0)
				drain();
		end
	endtask

	initial begin
		logic [7:0] opening [$];
		int k;
		idle_pct = 23;
		stall_pct = 23;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the limit
		reg_access(1'b0, LIMIT_ADDR, '0);

		// directed: NUL then a letter (no skip), 2/3/4-byte units, overlong
		// zero, largest 4-byte value, stray continuation, 0xFF and 0xF8 leads,
		// broken 3-byte lead, broken 4-byte sequence replaying its held bytes
		opening = '{8'h00, 8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'h80, 8'hFF, 8'hF8, 8'hE2, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h41};
		send_list(opening);
		// sequence cut off by end of string
		opening = '{8'hE2, 8'h82};
		send_list(opening);

		// zero keeps nothing
		set_limit(LIMIT_ADDR, 32'd0);
		run_phase(60);

		set_limit(LIMIT_ADDR, 32'd1);
		run_phase(60);

		// back-to-back stretch: no gaps on either side
		idle_pct = 0;
		stall_pct = 0;
		set_limit(LIMIT_ADDR, 32'd3);
		run_phase(60);
		idle_pct = 23;
		stall_pct = 23;

		mid_limit = LIMIT_W'($urandom_range(2, 40));
		set_limit(LIMIT_ADDR, {16'h0, mid_limit});
		run_phase(60);

		// write to an address with no register must leave the limit alone
		set_limit(UNUSED_ADDR, $urandom);

		// long ASCII string: the keep flag drops once the count passes the limit
		set_limit(LIMIT_ADDR, LONG_LIMIT);
		for (k = 0; k < LONG_BYTES; k++)
			send_byte(8'($urandom_range(0, 127)), k == LONG_BYTES - 1);
		strings_sent++;

		set_limit(LIMIT_ADDR, 32'hFFFF);
		run_phase(60);

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d bytes in %0d strings; %0d units compared, %0d invalid.",
			bytes_sent, strings_sent, units_checked, invalid_units);
		$display("Limits: reset, 0, 1, 3, %0d, %0d on a long ASCII string, 65535.",
			mid_limit, LONG_LIMIT);
		if (fail_count == 0 && units_pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/u8dct_pkg.sv
hw/rtl/u8dct_dp.sv
hw/rtl/u8dct_ctrl.sv
hw/rtl/utf8_decode_count_truncate_top.sv
sim/utf8_decode_count_truncate_checker.sv
sim/utf8_decode_count_truncate_top_test.sv
